>>> design/flow_pulse_totalizer_core_macros.svh
// Assertion helpers shared by the totalizer RTL.
`ifndef FLOW_PULSE_TOTALIZER_CORE_MACROS_SVH
`define FLOW_PULSE_TOTALIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FTOT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftot assertion failed");
// next-cycle implication
`define FTOT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftot assertion failed");
`else
`define FTOT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define FTOT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/ftot_pkg.sv
package ftot_pkg;

  localparam int TICK_W   = 24;
  localparam int COUNT_W  = 16;
  localparam int RATE_W   = 18;
  localparam int LITERS_W = 16;
  localparam int SERV_W   = 24;
  localparam int PCT_W    = 15;
  localparam int CFG_W    = 16;
  localparam int PROD_W   = 31;

  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // liters = floor(count * 256 / 450) = (count * ceil(2^31 / 225)) >> 24
  localparam int LITER_PROD_W = 40;
  localparam int LITER_SHIFT  = 24;

  localparam logic [RATE_W-1:0] RATE_FULL_Q8 = 18'd256000;
  localparam logic [23:0]       LITER_RECIP  = 24'd9544372;
  localparam logic [14:0]       PCT_SCALE    = 15'd25600;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam logic REG_IDX_FULL = 1'b0;
  localparam logic REG_IDX_PER  = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               rate_upd;
    logic [TICK_W-1:0]  ticks;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_WAIT,
    BK_OUT
  } back_state_t;

endpackage

>>> design/ftot_front.sv
module ftot_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic              pin_level,
  input  logic [15:0]       preset_count,
  input  logic              q_full,
  output logic              q_push,
  output ftot_pkg::job_t    q_data
);
  import ftot_pkg::*;

  logic               accept;
  logic               last_level, last_level_next;
  logic [TICK_W-1:0]  ticks, ticks_next;
  logic [COUNT_W-1:0] edge_total, edge_total_next;
  logic               rate_upd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    last_level_next = last_level;
    ticks_next      = ticks;
    edge_total_next = edge_total;
    rate_upd        = 1'b0;
    if (action == ACT_LOAD) begin
      edge_total_next = preset_count;
    end else if (pin_level == last_level) begin
      if (ticks != {TICK_W{1'b1}}) begin
        ticks_next = ticks + 1'b1;
      end
    end else begin
      if (pin_level) begin
        edge_total_next = edge_total + 1'b1;
      end
      last_level_next = pin_level;
      rate_upd        = 1'b1;
      ticks_next      = '0;
    end
  end

  // ticks is the pre-clear value: the rate is taken from it
  assign q_data = '{count: edge_total_next, rate_upd: rate_upd, ticks: ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b1;
      ticks      <= '0;
      edge_total <= '0;
    end else if (accept) begin
      last_level <= last_level_next;
      ticks      <= ticks_next;
      edge_total <= edge_total_next;
    end
  end

endmodule

>>> design/ftot_queue.sv
`include "flow_pulse_totalizer_core_macros.svh"

module ftot_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ftot_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output ftot_pkg::job_t pop_data,
  output logic           empty
);
  import ftot_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `FTOT_ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full)
  `FTOT_ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty)
  `FTOT_ASSERT_NEXT(a_push_not_empty, clk, rst, push && !pop, !empty)

endmodule

>>> design/ftot_div.sv
`include "flow_pulse_totalizer_core_macros.svh"

module ftot_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ftot_pkg::DIV_W-1:0] dividend,
  input  logic [ftot_pkg::DIV_W-1:0] divisor,
  output logic [ftot_pkg::DIV_W-1:0] quotient,
  output ftot_pkg::div_stat_t       stat
);
  import ftot_pkg::*;

  // restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0]     rem, dvd, dsr;
  logic [DIV_W:0]       trial, diff;
  logic                 ge;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy, done;

  assign trial    = {rem, dvd[DIV_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign ge       = (trial >= {1'b0, dsr});
  assign quotient = dvd;
  assign stat     = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd <= {dvd[DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `FTOT_ASSERT_NEXT(a_start_busy, clk, rst, start, busy)
  `FTOT_ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy)
  `FTOT_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)

endmodule

>>> design/ftot_back.sv
`include "flow_pulse_totalizer_core_macros.svh"

module ftot_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  ftot_pkg::job_t                q_data,
  input  logic [ftot_pkg::CFG_W-1:0]    full_pulse_count,
  input  logic [ftot_pkg::CFG_W-1:0]    pulses_per_serving,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ftot_pkg::COUNT_W-1:0]  pulse_count,
  output logic [ftot_pkg::RATE_W-1:0]   flow_rate_q8,
  output logic [ftot_pkg::LITERS_W-1:0] liters_q8,
  output logic [ftot_pkg::SERV_W-1:0]   servings_left_q8,
  output logic [ftot_pkg::PCT_W-1:0]    percent_left_q8
);
  import ftot_pkg::*;

  back_state_t        state, state_next;
  job_t               job;
  logic [COUNT_W-1:0] remain, remain_c;
  logic [PROD_W-1:0]  prod;
  logic [RATE_W-1:0]  held_rate, held_rate_next;
  logic               div_start, out_load, all_done;

  logic [LITER_PROD_W-1:0] liters_prod;
  logic [LITERS_W-1:0]     liters;

  logic [DIV_W-1:0] rate_dsr, serv_dsr, pct_dsr;
  logic [DIV_W-1:0] rate_q, serv_q, pct_q;
  div_stat_t        rate_st, serv_st, pct_st;

  assign remain_c = (full_pulse_count > job.count) ? full_pulse_count - job.count : '0;

  // divide by 450 as a reciprocal multiply
  assign liters_prod = LITER_PROD_W'(job.count) * LITER_PROD_W'(LITER_RECIP);

  assign rate_dsr = (job.ticks == '0) ? DIV_W'(1) : DIV_W'(job.ticks);
  assign serv_dsr = (pulses_per_serving == '0) ? DIV_W'(1) : DIV_W'(pulses_per_serving);
  assign pct_dsr  = (full_pulse_count == '0) ? DIV_W'(1) : DIV_W'(full_pulse_count);

  ftot_div u_div_rate (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(DIV_W'(RATE_FULL_Q8)), .divisor(rate_dsr),
    .quotient(rate_q), .stat(rate_st)
  );

  ftot_div u_div_serv (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(DIV_W'({remain, 8'd0})), .divisor(serv_dsr),
    .quotient(serv_q), .stat(serv_st)
  );

  ftot_div u_div_pct (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(DIV_W'(prod)), .divisor(pct_dsr),
    .quotient(pct_q), .stat(pct_st)
  );

  // all three start together and take the same number of steps
  assign all_done = rate_st.done && serv_st.done && pct_st.done;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_empty) state_next = BK_MUL;
      BK_MUL:  state_next = BK_DIV;
      BK_DIV:  state_next = BK_WAIT;
      BK_WAIT: if (all_done) state_next = BK_OUT;
      BK_OUT:  if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      BK_IDLE: q_pop     = !q_empty;
      BK_DIV:  div_start = 1'b1;
      BK_OUT:  out_load  = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    held_rate_next = held_rate;
    if (job.rate_upd) begin
      held_rate_next = (job.ticks == '0) ? RATE_FULL_Q8 : rate_q[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      held_rate <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        held_rate <= held_rate_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
    if (state == BK_MUL) begin
      remain <= remain_c;
      prod   <= PROD_W'(remain_c) * PROD_W'(PCT_SCALE);
      liters <= liters_prod[LITER_SHIFT +: LITERS_W];
    end
    if (out_load) begin
      pulse_count      <= job.count;
      flow_rate_q8     <= held_rate_next;
      liters_q8        <= liters;
      servings_left_q8 <= serv_q[SERV_W-1:0];
      percent_left_q8  <= pct_q[PCT_W-1:0];
    end
  end

  `FTOT_ASSERT_NEXT(a_load_shows, clk, rst, out_load, out_valid)
  `FTOT_ASSERT_IMPLIES(a_divs_in_step, clk, rst, rate_st.busy, serv_st.busy && pct_st.busy)
  `FTOT_ASSERT_IMPLIES(a_pop_idle, clk, rst, q_pop, state == BK_IDLE)

endmodule

>>> design/flow_pulse_totalizer_core.sv
// Flow sensor pulse totalizer.
// Input channel (in_valid/in_ready): one beat per 1 ms sample tick carrying
// the pin level (action = tick), or a load beat that presets the pulse count.
// Output channel (out_valid/out_ready): exactly one result beat per input
// beat, in order: pulse count, held flow rate (Hz, Q.8), liters, servings
// left and percent left (all Q.8).
// An accepted beat passes the queue and the back end's MUL, DIV, WAIT and
// OUT states. The back end takes a new job only after loading the last one;
// its pace is set by the 32-step bit-serial dividers (three run side by
// side: rate, servings, percent; liters: reciprocal multiply by 1/450).
// The front end updates edge/tick state in the cycle of acceptance and
// pushes a job into a 4-entry queue, so it keeps taking beats while the back
// end computes or while a finished result waits in the output register.
// Receiver stall: the result holds in the output register; once the queue
// also fills, in_ready drops.
// Reset (rst, synchronous): last level high, counters and held rate zero,
// full_pulse_count = 65535, pulses_per_serving = 1. No clearing pass.
// Config: APB, reg 0 at 0x0 (full count), reg 1 at 0x4 (pulses/serving);
// write only while idle.
module flow_pulse_totalizer_core (
  input  logic        clk,
  input  logic        rst,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic        pin_level,
  input  logic [15:0] preset_count,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pulse_count,
  output logic [17:0] flow_rate_q8,
  output logic [15:0] liters_q8,
  output logic [23:0] servings_left_q8,
  output logic [14:0] percent_left_q8
);
  import ftot_pkg::*;

  logic [CFG_W-1:0] full_pulse_count;
  logic [CFG_W-1:0] pulses_per_serving;
  logic             cfg_wr;

  logic q_push, q_pop, q_full, q_empty;
  job_t q_wdata, q_rdata;

  // APB: zero wait states; word select on paddr[2], low bits ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_pulse_count   <= 16'hFFFF;
      pulses_per_serving <= 16'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IDX_FULL) begin
        full_pulse_count <= pwdata[CFG_W-1:0];
      end else begin
        pulses_per_serving <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IDX_FULL: prdata = {16'd0, full_pulse_count};
      REG_IDX_PER:  prdata = {16'd0, pulses_per_serving};
      default:      prdata = '0;
    endcase
  end

  // front: edge detect, tick counting, pulse count
  ftot_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .pin_level(pin_level), .preset_count(preset_count),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  // decouples front and back
  ftot_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
  );

  // back: rate hold, the divides and the liters multiply, output register
  ftot_back u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_pop(q_pop), .q_data(q_rdata),
    .full_pulse_count(full_pulse_count), .pulses_per_serving(pulses_per_serving),
    .out_valid(out_valid), .out_ready(out_ready),
    .pulse_count(pulse_count), .flow_rate_q8(flow_rate_q8),
    .liters_q8(liters_q8), .servings_left_q8(servings_left_q8),
    .percent_left_q8(percent_left_q8)
  );

endmodule
